[sv/ihe_pkg.sv]
// shared types and constants of the indexed min-heap engine
// used by ihe_ctrl, ihe_dp and indexed_min_heap_engine_core; no dependencies
`default_nettype none

package ihe_pkg;

    localparam int ID_W          = 8;
    localparam int NUM_IDS       = 256;
    localparam int IO_COST_W     = 32;
    localparam int COUNT_W       = 9;
    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_COST_BITS = 32;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POPMIN = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_UPDATE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [ID_W-1:0]      item_id;
        logic [IO_COST_W-1:0] new_cost;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_W-1:0]      out_id;
        logic [IO_COST_W-1:0] out_cost;
        logic [COUNT_W-1:0]   entry_count;
    } rsp_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ERR_FULL,
        OP_ERR_EMPTY,
        OP_ERR_ABSENT,
        OP_INSERT,
        OP_UPDATE,
        OP_RD_ROOT,
        OP_RD_SLOT,
        OP_TAKE,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_PLACE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       id_valid;
        logic       full;
        logic       empty;
        logic       take_more;
        logic       pos_zero;
        logic       moved;
        logic       up_go;
        logic       has_child;
        logic       down_go;
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/ihe_dp.sv]
// datapath of the indexed min-heap engine: heap slot memories, id map, sift registers
// depends on ihe_pkg
`default_nettype none

module ihe_dp
    import ihe_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire dp_cmd_t  cmd,
    output dp_stat_t      stat,
    output rsp_t          result
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = SLOT_W + 2;

    // memories
    logic [ID_W-1:0]      heap_id   [CAPACITY];
    logic [COST_BITS-1:0] heap_cost [CAPACITY];
    logic [SLOT_W-1:0]    map_mem   [NUM_IDS];

    // registers
    logic [1:0]           req_reg;
    logic [ID_W-1:0]      id_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [ID_W-1:0]      cur_id_reg;
    logic [COST_BITS-1:0] cur_cost_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 moved_reg;
    logic [NUM_IDS-1:0]   valid_reg;
    logic [1:0]           status_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [COST_BITS-1:0] out_cost_reg;
    logic [SLOT_W-1:0]    map_q_reg;
    logic [ID_W-1:0]      a_id_reg;
    logic [COST_BITS-1:0] a_cost_reg;
    logic [ID_W-1:0]      b_id_reg;
    logic [COST_BITS-1:0] b_cost_reg;

    logic [SLOT_W-1:0]    addr_a;
    logic [SLOT_W-1:0]    addr_b;
    logic                 heap_we;
    logic [SLOT_W-1:0]    heap_wa;
    logic [ID_W-1:0]      heap_wid;
    logic [COST_BITS-1:0] heap_wcost;

    logic [IDX_W-1:0]     pos_x;
    logic [IDX_W-1:0]     fill_x;
    logic [IDX_W-1:0]     left_x;
    logic [IDX_W-1:0]     right_x;
    logic [SLOT_W-1:0]    parent;
    logic [SLOT_W-1:0]    last;
    logic                 pick_right;
    logic [SLOT_W-1:0]    best_pos;
    logic [ID_W-1:0]      best_id;
    logic [COST_BITS-1:0] best_cost;
    logic [COST_BITS-1:0] in_cost;
    logic [COST_BITS+IO_COST_W-1:0] in_cost_x;
    logic [COST_BITS+IO_COST_W-1:0] out_cost_x;
    logic [CNT_W+COUNT_W-1:0]       count_x;

    // index arithmetic
    always_comb
    begin
        pos_x      = IDX_W'(pos_reg);
        fill_x     = IDX_W'(fill_reg);
        left_x     = {1'b0, pos_reg, 1'b1};
        right_x    = left_x + IDX_W'(1);
        parent     = SLOT_W'((pos_reg - SLOT_W'(1)) >> 1);
        last       = SLOT_W'(fill_reg - CNT_W'(1));
        pick_right = (right_x < fill_x) && (b_cost_reg < a_cost_reg);
        best_pos   = pick_right ? right_x[SLOT_W-1:0] : left_x[SLOT_W-1:0];
        best_id    = pick_right ? b_id_reg : a_id_reg;
        best_cost  = pick_right ? b_cost_reg : a_cost_reg;
        in_cost_x  = (COST_BITS + IO_COST_W)'(req.new_cost);
        in_cost    = in_cost_x[COST_BITS-1:0];
        out_cost_x = (COST_BITS + IO_COST_W)'(out_cost_reg);
        count_x    = (CNT_W + COUNT_W)'(fill_reg);
    end

    // read addresses and write port selection
    always_comb
    begin
        addr_a     = '0;
        addr_b     = last;
        heap_we    = 1'b0;
        heap_wa    = pos_reg;
        heap_wid   = cur_id_reg;
        heap_wcost = cur_cost_reg;
        case (cmd.op)
            OP_UP_READ: addr_a = parent;
            OP_DN_READ:
            begin
                addr_a = left_x[SLOT_W-1:0];
                addr_b = right_x[SLOT_W-1:0];
            end
            OP_UP_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wid   = a_id_reg;
                heap_wcost = a_cost_reg;
            end
            OP_DN_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wid   = best_id;
                heap_wcost = best_cost;
            end
            OP_PLACE: heap_we = 1'b1;
            default: ;
        endcase
    end

    // heap slot memories, two registered read ports
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_id[heap_wa]   <= heap_wid;
            heap_cost[heap_wa] <= heap_wcost;
        end
        a_id_reg   <= heap_id[addr_a];
        a_cost_reg <= heap_cost[addr_a];
        b_id_reg   <= heap_id[addr_b];
        b_cost_reg <= heap_cost[addr_b];
    end

    // id to slot map memory
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            map_mem[heap_wid] <= heap_wa;
        end
        if (cmd.op == OP_CAPTURE)
        begin
            map_q_reg <= map_mem[req.item_id];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                req_reg      <= req.req_type;
                id_reg       <= req.item_id;
                cost_reg     <= in_cost;
                out_id_reg   <= '0;
                out_cost_reg <= '0;
            end
            OP_INSERT:
            begin
                cur_id_reg   <= id_reg;
                cur_cost_reg <= cost_reg;
                pos_reg      <= fill_reg[SLOT_W-1:0];
            end
            OP_UPDATE:
            begin
                cur_id_reg   <= id_reg;
                cur_cost_reg <= cost_reg;
                pos_reg      <= map_q_reg;
            end
            OP_RD_ROOT: pos_reg <= '0;
            OP_RD_SLOT: pos_reg <= map_q_reg;
            OP_TAKE:
            begin
                cur_id_reg   <= b_id_reg;
                cur_cost_reg <= b_cost_reg;
                if (req_reg == REQ_POPMIN)
                begin
                    out_id_reg   <= a_id_reg;
                    out_cost_reg <= a_cost_reg;
                end
            end
            OP_UP_MOVE: pos_reg <= parent;
            OP_DN_MOVE: pos_reg <= best_pos;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            moved_reg  <= 1'b0;
            valid_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            case (cmd.op)
                OP_CAPTURE:    status_reg <= ST_OK;
                OP_ERR_FULL:   status_reg <= ST_FULL;
                OP_ERR_EMPTY:  status_reg <= ST_EMPTY;
                OP_ERR_ABSENT: status_reg <= ST_ABSENT;
                OP_INSERT:
                begin
                    fill_reg          <= fill_reg + CNT_W'(1);
                    valid_reg[id_reg] <= 1'b1;
                    moved_reg         <= 1'b0;
                end
                OP_UPDATE: moved_reg <= 1'b0;
                OP_TAKE:
                begin
                    fill_reg  <= fill_reg - CNT_W'(1);
                    moved_reg <= 1'b0;
                    if (req_reg == REQ_POPMIN)
                    begin
                        valid_reg[a_id_reg] <= 1'b0;
                    end
                    else
                    begin
                        valid_reg[id_reg] <= 1'b0;
                    end
                end
                OP_UP_MOVE: moved_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.req_type  = req_reg;
        stat.id_valid  = valid_reg[id_reg];
        stat.full      = (fill_reg == CNT_W'(CAPACITY));
        stat.empty     = (fill_reg == '0);
        stat.take_more = (pos_x + IDX_W'(1)) < fill_x;
        stat.pos_zero  = (pos_reg == '0);
        stat.moved     = moved_reg;
        stat.up_go     = a_cost_reg > cur_cost_reg;
        stat.has_child = left_x < fill_x;
        stat.down_go   = cur_cost_reg > best_cost;
    end

    // result
    always_comb
    begin
        result.status      = status_reg;
        result.out_id      = out_id_reg;
        result.out_cost    = out_cost_x[IO_COST_W-1:0];
        result.entry_count = count_x[COUNT_W-1:0];
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");
    a_place_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PLACE) |-> (pos_x < fill_x))
        else $error("entry placed outside the heap");
    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_UP_MOVE) |-> (pos_reg != '0))
        else $error("sift up moved past the root");

endmodule

`default_nettype wire

[sv/ihe_ctrl.sv]
// controller state machine of the indexed min-heap engine
// depends on ihe_pkg; drives ihe_dp through dp_cmd_t, reads dp_stat_t
`default_nettype none

module ihe_ctrl
    import ihe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          result_strobe
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RM_TAKE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   strobe_reg;

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (stat.req_type)
                    REQ_INSERT:
                    begin
                        if (stat.id_valid)
                        begin
                            cmd.op     = OP_UPDATE;
                            state_next = S_UP_RD;
                        end
                        else if (stat.full)
                        begin
                            cmd.op = OP_ERR_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_INSERT;
                            state_next = S_UP_RD;
                        end
                    end
                    REQ_POPMIN:
                    begin
                        if (stat.empty)
                        begin
                            cmd.op = OP_ERR_EMPTY;
                        end
                        else
                        begin
                            cmd.op     = OP_RD_ROOT;
                            state_next = S_RM_TAKE;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!stat.id_valid)
                        begin
                            cmd.op = OP_ERR_ABSENT;
                        end
                        else
                        begin
                            cmd.op     = OP_RD_SLOT;
                            state_next = S_RM_TAKE;
                        end
                    end
                    default:
                    begin
                        if (!stat.id_valid)
                        begin
                            cmd.op = OP_ERR_ABSENT;
                        end
                        else
                        begin
                            cmd.op     = OP_UPDATE;
                            state_next = S_UP_RD;
                        end
                    end
                endcase
            end
            S_RM_TAKE:
            begin
                cmd.op     = OP_TAKE;
                state_next = stat.take_more ? S_UP_RD : S_DONE;
            end
            S_UP_RD:
            begin
                if (stat.pos_zero)
                begin
                    state_next = stat.moved ? S_PLACE : S_DN_RD;
                end
                else
                begin
                    cmd.op     = OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_go)
                begin
                    cmd.op     = OP_UP_MOVE;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = stat.moved ? S_PLACE : S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                if (stat.has_child)
                begin
                    cmd.op     = OP_DN_READ;
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_DN_CMP:
            begin
                if (stat.down_go)
                begin
                    cmd.op     = OP_DN_MOVE;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.op     = OP_PLACE;
                state_next = S_DONE;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= (state_next != S_IDLE);
            strobe_reg <= (state_next == S_DONE);
        end
    end

    assign busy          = busy_reg;
    assign result_strobe = strobe_reg;

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !busy)
        else $error("busy still high after result transfer");
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_CMP) |-> ($past(state_reg) == S_UP_RD))
        else $error("parent compare without parent read");

endmodule

`default_nettype wire

[sv/indexed_min_heap_engine_core.sv]
// top level of the indexed min-heap engine: controller plus datapath
// depends on ihe_pkg, ihe_ctrl, ihe_dp
//
// usage
//   request channel: drive req and raise start; the request transfers at the
//   rising edge where start is high and busy is low. busy then stays high
//   until the result has been shown.
//   result channel: result holds status, out_id, out_cost and entry_count,
//   marked by result_strobe for exactly one cycle; the receiver takes it at
//   the edge that ends that cycle and cannot stall it.
//   steps: an error ends after dispatch; otherwise each sift level is one
//   heap memory read, then one compare and move, between setup and final
//   placement, since the loop runs through the registered heap memory read.
//   throughput: one request at a time; busy drops the cycle after the
//   result strobe.
//   reset: rst_n clears the fill count and all id present bits at once; the
//   heap slot memories need no clearing pass.
`default_nettype none

module indexed_min_heap_engine_core
    import ihe_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      result_strobe,
    output rsp_t      result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ihe_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    ihe_dp #(
        .CAPACITY  (CAPACITY),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire
